// ----- rtl/topk_weighted_interval_overlap_unit_macros.svh -----
// Assertion macros shared by the interval overlap unit RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef TOPK_WEIGHTED_INTERVAL_OVERLAP_UNIT_MACROS_SVH
`define TOPK_WEIGHTED_INTERVAL_OVERLAP_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define TWIO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define TWIO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/twio_pkg.sv -----
// Package of the interval overlap unit: opcodes, status codes, entry type, states.
// Depends on nothing.
package twio_pkg;
    localparam int IdW  = 24;
    localparam int ValW = 31;
    localparam int EntW = IdW + 3 * ValW;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic [IdW-1:0]  id;
        logic [ValW-1:0] lo;
        logic [ValW-1:0] hi;
        logic [ValW-1:0] wt;
    } t_entry;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [IdW-1:0]  interval_id;
        logic [ValW-1:0] range_start;
        logic [ValW-1:0] range_end;
        logic [ValW-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [IdW-1:0]  match_id;
        logic [ValW-1:0] match_start;
        logic [ValW-1:0] match_end;
        logic [ValW-1:0] match_weight;
        logic            last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_L_RD,     // read entry at index (search)
        S_L_CMP,    // compare read weight
        S_L_SHRD,   // read entry idx-1 for shifting
        S_L_SHWR,   // write it to idx
        S_L_INS,    // write new entry
        S_Q_RD,
        S_Q_CMP,
        S_EMIT,     // result pending in output register
        S_Q_NONE,
        S_Q_LAST    // send the held match as the final result
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic take;        // capture input item
        logic clr_cnt;
        logic inc_cnt;
        logic idx_zero;
        logic idx_cnt;     // idx <= count, remember insert position
        logic idx_inc;
        logic idx_dec;
        logic rd_idx;      // read ram at idx
        logic rd_idx_m1;   // read ram at idx-1
        logic wr_rd;       // write last read data at idx
        logic wr_new;      // write captured item at idx
        logic emit_full;
        logic emit_match;  // hold this match, send the previous one
        logic emit_none;
        logic emit_last;   // send the held match with last set
        logic hit_inc;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        t_opcode op;
        logic    full;
        logic    idx_at_cnt;   // idx == count
        logic    idx_at_pos;   // idx == insert position
        logic    wt_ge;        // read weight >= new weight
        logic    overlap;
        logic    hit_at_lim;   // hits+1 == limit
        logic    hits_zero;
        logic    out_busy;
    } t_stat;
endpackage

// ----- rtl/twio_if.sv -----
// Valid/ready channel interface carrying a packed payload.
// Depends on nothing; the payload type is a parameter.
interface twio_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/topk_weighted_interval_overlap_unit.sv -----
// Top-k weighted interval overlap unit (top level).
// Channels: i_in (sink) takes a request of opcode, interval_id, range_start,
// range_end, weight; o_out (source) delivers results of status, match_id,
// match_start, match_end, match_weight and last. Both are valid/ready, a
// request moving at a rising edge with valid and ready high. i_cfg_we and
// i_cfg_data write result_limit (k), reset value 5; zero acts as one and
// values above MAX_K act as MAX_K.
// One request is worked at a time. A clear empties the store count, and a load into
// a full store only reports full. A query reads then compares each stored entry
// scanned on the single RAM port, up to all CAPACITY entries. A load searches its
// place, reading and comparing each entry, and when it does not land at the end
// shifts the tail one entry at a time, each read and then written. The single-port
// store sets this stepwise order.
// A match is held back one step so that last can mark the final one; it enters
// the output register when the next match is found or the scan ends. When the
// receiver stalls the scan pauses there, and a new request is accepted only
// once the output register is free.
// Reset (synchronous, active low) empties the store count, restores k = 5
// and drops any pending result; store contents are left undefined.
module topk_weighted_interval_overlap_unit import twio_pkg::*; #(
    parameter int CAPACITY = 1024,
    parameter int MAX_K    = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    twio_if.sink       i_in,
    twio_if.source     o_out
);
    t_cmd  cmd;
    t_stat stat;

    // The controller sequences every request; the datapath owns all storage.
    twio_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    twio_datapath #(.Capacity(CAPACITY), .MaxK(MAX_K)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in.data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_out_ready(o_out.ready),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_valid(o_out.valid),
        .o_out      (o_out.data)
    );
endmodule

// ----- rtl/twio_ram.sv -----
// Generic single-port RAM with registered read.
// Depends on nothing.
module twio_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- rtl/twio_datapath.sv -----
// Datapath: input capture, entry store, index/count/hit counters, result register.
// Depends on twio_pkg, twio_ram and the macros header.
`include "topk_weighted_interval_overlap_unit_macros.svh"
module twio_datapath import twio_pkg::*; #(
    parameter int Capacity = 1024,
    parameter int MaxK     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_item,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_out_ready,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_out_valid,
    output t_out_item   o_out
);
    localparam int AW = $clog2(Capacity);
    localparam int CW = $clog2(Capacity + 1);
    localparam int KW = $clog2(MaxK + 1);

    t_in_item        r_item;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_pos;
    logic [6:0]      r_lim;
    logic [KW-1:0]   r_hits;
    logic            r_out_valid;
    t_out_item       r_out;
    t_entry          r_pend;
    logic [KW-1:0]   lim_eff;
    logic [CW-1:0]   idx_m1;
    logic [AW-1:0]   addr;
    logic            we;
    logic [EntW-1:0] wdata, rdata;
    t_entry          rd_ent;
    t_entry          new_ent;
    logic            push_pend;

    assign idx_m1  = r_idx - CW'(1);
    assign rd_ent  = t_entry'(rdata);
    assign new_ent = '{id: r_item.interval_id, lo: r_item.range_start,
                       hi: r_item.range_end, wt: r_item.weight};

    // The held match leaves when the next match arrives or the scan ends.
    assign push_pend = i_cmd.emit_last || (i_cmd.emit_match && (r_hits != '0));

    always_comb begin
        if (r_lim == 7'd0) begin
            lim_eff = KW'(1);
        end else if (32'(r_lim) > MaxK) begin
            lim_eff = KW'(MaxK);
        end else begin
            lim_eff = KW'(r_lim);
        end
    end

    always_comb begin
        addr  = r_idx[AW-1:0];
        if (i_cmd.rd_idx_m1) begin
            addr = idx_m1[AW-1:0];
        end
        we    = i_cmd.wr_rd | i_cmd.wr_new;
        wdata = i_cmd.wr_new ? EntW'(new_ent) : rdata;
    end

    twio_ram #(.Width(EntW), .Depth(Capacity)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_item <= i_item;
        end
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_lim       <= 7'd5;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lim <= i_cfg_data;
            end
            if (i_cmd.clr_cnt) begin
                r_cnt <= '0;
            end else if (i_cmd.inc_cnt) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.idx_cnt) begin
                r_pos <= r_idx;
            end
            if (i_cmd.idx_zero) begin
                r_idx <= '0;
            end else if (i_cmd.idx_cnt) begin
                r_idx <= r_cnt;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_cmd.idx_dec) begin
                r_idx <= idx_m1;
            end
            if (i_cmd.take) begin
                r_hits <= '0;
            end else if (i_cmd.hit_inc) begin
                r_hits <= r_hits + KW'(1);
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.emit_full || i_cmd.emit_none || push_pend) begin
                r_out_valid <= 1'b1;
            end
        end
        if (i_cmd.emit_match) begin
            r_pend <= rd_ent;
        end
        if (i_cmd.emit_full || i_cmd.emit_none) begin
            r_out <= '{status: i_cmd.emit_full ? ST_FULL : ST_NOMATCH,
                       match_id: '0, match_start: '0, match_end: '0,
                       match_weight: '0, last: 1'b1};
        end else if (push_pend) begin
            r_out <= '{status: ST_MATCH, match_id: r_pend.id, match_start: r_pend.lo,
                       match_end: r_pend.hi, match_weight: r_pend.wt,
                       last: i_cmd.emit_last};
        end
    end

    always_comb begin
        o_stat.op         = t_opcode'(r_item.opcode);
        o_stat.full       = (r_cnt == CW'(Capacity));
        o_stat.idx_at_cnt = (r_idx == r_cnt);
        o_stat.idx_at_pos = (r_idx == r_pos);
        o_stat.wt_ge      = (rd_ent.wt >= r_item.weight);
        o_stat.overlap    = (rd_ent.hi >= r_item.range_start) &&
                            (rd_ent.lo <= r_item.range_end);
        o_stat.hit_at_lim = (r_hits + KW'(1) == lim_eff);
        o_stat.hits_zero  = (r_hits == '0);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TWIO_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(Capacity),
        "stored count above capacity")
    `TWIO_ASSERT_IMP(a_hits_bound, i_clk, i_rst_n, 1'b1, r_hits <= KW'(MaxK),
        "more hits than the largest limit")
    `TWIO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready,
        r_out_valid && $stable(r_out), "pending result changed while stalled")
endmodule

// ----- rtl/twio_ctrl.sv -----
// Controller state machine sequencing loads, queries and clears.
// Depends on twio_pkg and the macros header.
`include "topk_weighted_interval_overlap_unit_macros.svh"
module twio_ctrl import twio_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The idle state also waits for a pending result to drain before new work.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_stat.out_busy) begin
                    n_state = S_L_RD;
                end
            end
            S_L_RD: begin
                case (i_stat.op)
                    OP_LOAD:  n_state = i_stat.full ? S_EMIT :
                                        (i_stat.idx_at_cnt ? S_L_INS : S_L_CMP);
                    OP_QUERY: n_state = i_stat.idx_at_cnt ? S_Q_NONE : S_Q_CMP;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_L_CMP: begin
                if (!i_stat.wt_ge) begin
                    n_state = S_L_SHRD;
                end else begin
                    n_state = S_L_RD;
                end
            end
            S_L_SHRD: n_state = i_stat.idx_at_pos ? S_L_INS : S_L_SHWR;
            S_L_SHWR: n_state = S_L_SHRD;
            S_L_INS:  n_state = S_IDLE;
            S_Q_RD:   n_state = i_stat.idx_at_cnt ?
                                (i_stat.hits_zero ? S_Q_NONE : S_Q_LAST) : S_Q_CMP;
            S_Q_CMP: begin
                if (i_stat.overlap) begin
                    if (i_stat.out_busy) begin
                        n_state = S_Q_CMP;
                    end else if (i_stat.hit_at_lim) begin
                        n_state = S_Q_LAST;
                    end else begin
                        n_state = S_Q_RD;
                    end
                end else begin
                    n_state = S_Q_RD;
                end
            end
            S_Q_NONE: n_state = i_stat.out_busy ? S_Q_NONE : S_IDLE;
            S_Q_LAST: n_state = i_stat.out_busy ? S_Q_LAST : S_IDLE;
            S_EMIT:   n_state = i_stat.out_busy ? S_EMIT : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // S_L_RD doubles as the decode state after the item is taken in S_IDLE;
    // for a load the first search read is issued from there at index zero.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = !i_stat.out_busy;
                if (i_in_valid && !i_stat.out_busy) begin
                    o_cmd.take     = 1'b1;
                    o_cmd.idx_zero = 1'b1;
                end
            end
            S_L_RD: begin
                o_cmd.rd_idx = 1'b1;
                if (i_stat.op == OP_CLEAR) begin
                    o_cmd.clr_cnt = 1'b1;
                end
                if (i_stat.op == OP_LOAD && i_stat.full) begin
                    o_cmd.emit_full = 1'b1;
                end
            end
            S_L_CMP: begin
                if (!i_stat.wt_ge) begin
                    o_cmd.idx_cnt = 1'b1;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_L_SHRD: o_cmd.rd_idx_m1 = 1'b1;
            S_L_SHWR: begin
                o_cmd.wr_rd   = 1'b1;
                o_cmd.idx_dec = 1'b1;
            end
            S_L_INS: begin
                o_cmd.wr_new  = 1'b1;
                o_cmd.inc_cnt = 1'b1;
            end
            S_Q_RD: o_cmd.rd_idx = 1'b1;
            S_Q_CMP: begin
                if (i_stat.overlap) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.emit_match = 1'b1;
                        o_cmd.hit_inc    = 1'b1;
                        o_cmd.idx_inc    = 1'b1;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_Q_NONE: o_cmd.emit_none = !i_stat.out_busy;
            S_Q_LAST: o_cmd.emit_last = !i_stat.out_busy;
            S_EMIT:   ;
            default:  ;
        endcase
    end

    `TWIO_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE,
        "input ready outside idle")
    `TWIO_ASSERT_IMP(a_no_emit_busy, i_clk, i_rst_n,
        o_cmd.emit_match || o_cmd.emit_none || o_cmd.emit_full || o_cmd.emit_last,
        !i_stat.out_busy, "result issued over a pending one")
    `TWIO_ASSERT_IMP(a_one_write, i_clk, i_rst_n, 1'b1, !(o_cmd.wr_rd && o_cmd.wr_new),
        "two store writes in one cycle")
endmodule
